/* rtl/isbs_pkg.sv */
// Package of the orientation sample buffer: sizes, opcodes, payload and entry types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package isbs_pkg;

	localparam int RING_DEPTH = 32;
	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int ADDR_W = 4;

	localparam logic [1:0] OP_ADD_QUAT = 2'd0;
	localparam logic [1:0] OP_ADD_EULER = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] REG_RETENTION = 2'd0;
	localparam logic [1:0] REG_QUERY_LIMIT = 2'd1;
	localparam logic [1:0] REG_EULER_MATCH = 2'd2;

	localparam logic [31:0] RETENTION_RESET = 32'd100000;
	localparam logic [31:0] QUERY_LIMIT_RESET = 32'd10000;
	localparam logic [31:0] EULER_MATCH_RESET = 32'd10000;

	localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] sample_time;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] roll_in;
		logic signed [15:0] pitch_in;
		logic signed [15:0] yaw_in;
	} in_t;

	typedef struct packed {
		logic found;
		logic [31:0] out_time;
		logic signed [15:0] out_quat_w;
		logic signed [15:0] out_quat_x;
		logic signed [15:0] out_quat_y;
		logic signed [15:0] out_quat_z;
		logic signed [15:0] out_roll;
		logic signed [15:0] out_pitch;
		logic signed [15:0] out_yaw;
		logic out_has_euler;
		logic [5:0] occupancy;
	} out_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic euler;
	} entry_t;

	// Control from the sequencer to the chain of cells.
	typedef struct packed {
		logic shift;
		logic wr_all;
		logic wr_ang;
		logic [IDX_W-1:0] widx;
	} chain_ctl_t;

	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* rtl/imu_timestamp_sync_buffer_top.sv */
// Top level of the orientation sample buffer: APB registers, sequencer, output register.
// Depends on isbs_pkg and isbs_chain.
`timescale 1ns / 1ps
// From one accepted transfer to the next, a clear and a query on an empty ring go straight
// to output. An add of a quaternion or an add of angles on an empty ring goes through
// append, cutoff, expiry and output. A query or an add of angles on a non-empty ring first
// rotates the whole 32-cell chain once past its head, where one comparator looks at one
// entry per cycle; a query then goes to output, an add of angles to cutoff, expiry and
// output. One item is in work at a time. The result register lets the next item be taken
// while a result waits, but a second result stalls until the first one is taken.
// Configuration is read and written over APB; write it only while no item is in work.
module imu_timestamp_sync_buffer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  isbs_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output isbs_pkg::out_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [isbs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import isbs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_APP = 3'd1;
	localparam logic [2:0] ST_ROT = 3'd2;
	localparam logic [2:0] ST_FIN = 3'd3;
	localparam logic [2:0] ST_CUT = 3'd4;
	localparam logic [2:0] ST_EXP = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [31:0] ret_q, qlim_q, ematch_q;
	logic [2:0] state_q;
	in_t item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] k_q, mk_q;
	logic mfound_q;
	logic [31:0] newest_q;
	logic [32:0] cut_q;
	entry_t best_q, last_q;
	logic [31:0] bestd_q;
	out_t res_q, res_d;
	logic out_valid_q;
	chain_ctl_t ctl;
	entry_t wdata, head;
	logic [31:0] head_dist;
	logic k_valid, full;
	logic out_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= RETENTION_RESET;
			qlim_q <= QUERY_LIMIT_RESET;
			ematch_q <= EULER_MATCH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RETENTION: ret_q <= pwdata;
				REG_QUERY_LIMIT: qlim_q <= pwdata;
				REG_EULER_MATCH: ematch_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RETENTION: prdata = ret_q;
			REG_QUERY_LIMIT: prdata = qlim_q;
			REG_EULER_MATCH: prdata = ematch_q;
			default: prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	assign full = (cnt_q == CNT_W'(RING_DEPTH));
	assign head_dist = abs_diff(head.stamp, item_q.sample_time);
	assign k_valid = ({1'b0, k_q} < (IDX_W+1)'(cnt_q));
	assign out_fire = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		ctl = '0;
		wdata = '0;
		wdata.stamp = item_q.sample_time;
		wdata.roll = item_q.roll_in;
		wdata.pitch = item_q.pitch_in;
		wdata.yaw = item_q.yaw_in;
		case (state_q)
			ST_APP: begin
				ctl.wr_all = 1'b1;
				ctl.shift = full;
				ctl.widx = full ? IDX_W'(RING_DEPTH - 1) : cnt_q[IDX_W-1:0];
				if (item_q.opcode == OP_ADD_QUAT) begin
					wdata.qw = item_q.quat_w;
					wdata.qx = item_q.quat_x;
					wdata.qy = item_q.quat_y;
					wdata.qz = item_q.quat_z;
					wdata.roll = '0;
					wdata.pitch = '0;
					wdata.yaw = '0;
				end else begin
					wdata.qw = QUAT_ONE;
					wdata.euler = 1'b1;
				end
			end
			ST_ROT: ctl.shift = 1'b1;
			ST_FIN: begin
				ctl.wr_ang = (item_q.opcode == OP_ADD_EULER) && mfound_q;
				ctl.widx = mk_q;
			end
			ST_EXP: ctl.shift = (cnt_q != '0) && !cut_q[32] && (head.stamp < cut_q[31:0]);
			default: ;
		endcase
	end

	isbs_chain u_chain (
		.clk(clk),
		.ctl(ctl),
		.wdata(wdata),
		.head(head)
	);

	always_comb begin
		entry_t pick;
		pick = (bestd_q < qlim_q) ? best_q : last_q;
		res_d = '0;
		res_d.occupancy = 6'(cnt_q);
		if (item_q.opcode == OP_QUERY && cnt_q != '0) begin
			res_d.found = 1'b1;
			res_d.out_time = pick.stamp;
			res_d.out_quat_w = pick.qw;
			res_d.out_quat_x = pick.qx;
			res_d.out_quat_y = pick.qy;
			res_d.out_quat_z = pick.qz;
			res_d.out_roll = pick.roll;
			res_d.out_pitch = pick.pitch;
			res_d.out_yaw = pick.yaw;
			res_d.out_has_euler = pick.euler;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == ST_APP) begin
			newest_q <= item_q.sample_time;
		end
		if (state_q == ST_CUT) begin
			cut_q <= {1'b0, newest_q} - {1'b0, ret_q};
		end
		if (state_q == ST_ROT && k_valid) begin
			if (k_q == '0 || head_dist < bestd_q) begin
				best_q <= head;
				bestd_q <= head_dist;
			end
			if ({1'b0, k_q} == (IDX_W+1)'(cnt_q - 1'b1)) begin
				last_q <= head;
			end
			if (head_dist < ematch_q) begin
				mk_q <= k_q;
			end
		end
		if (out_fire) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			mfound_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						k_q <= '0;
						mfound_q <= 1'b0;
						case (in_data.opcode)
							OP_ADD_QUAT: state_q <= ST_APP;
							OP_ADD_EULER: state_q <= (cnt_q == '0) ? ST_APP : ST_ROT;
							OP_QUERY: state_q <= (cnt_q == '0) ? ST_OUT : ST_ROT;
							default: begin
								cnt_q <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_APP: begin
					if (!full) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_CUT;
				end
				ST_ROT: begin
					if (k_valid && head_dist < ematch_q) begin
						mfound_q <= 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == IDX_W'(RING_DEPTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= (item_q.opcode == OP_QUERY) ? ST_OUT : ST_CUT;
				ST_CUT: state_q <= ST_EXP;
				ST_EXP: begin
					if (ctl.shift) begin
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RING_DEPTH))
		else $error("entry count beyond ring depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.opcode == OP_CLEAR) |=> (cnt_q == '0))
		else $error("clear left entries in the ring");

	a_expire_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXP && cnt_q == '0) |=> (state_q == ST_OUT))
		else $error("expiry ran on an empty ring");

	a_result_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> (out_data.occupancy == 6'(cnt_q)))
		else $error("reported occupancy differs from entry count");
endmodule

/* rtl/isbs_cell.sv */
// One slot of the sample chain: holds an entry, takes its neighbor's entry on a shift.
// Depends on isbs_pkg.
`timescale 1ns / 1ps
module isbs_cell (
	input  logic clk,
	input  logic shift,
	input  logic wr_all,
	input  logic wr_ang,
	input  isbs_pkg::entry_t wdata,
	input  isbs_pkg::entry_t nbr,
	output isbs_pkg::entry_t ent
);
	import isbs_pkg::*;

	entry_t ent_q;

	// A write wins over the shift so a full ring can drop and append in the same cycle.
	always_ff @(posedge clk) begin
		if (wr_all) begin
			ent_q <= wdata;
		end else if (wr_ang) begin
			ent_q.roll <= wdata.roll;
			ent_q.pitch <= wdata.pitch;
			ent_q.yaw <= wdata.yaw;
			ent_q.euler <= 1'b1;
		end else if (shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;
endmodule

/* rtl/isbs_chain.sv */
// Ring of sample cells kept in age order, oldest at the head; rotates toward the head.
// Depends on isbs_pkg and isbs_cell.
`timescale 1ns / 1ps
module isbs_chain (
	input  logic clk,
	input  isbs_pkg::chain_ctl_t ctl,
	input  isbs_pkg::entry_t wdata,
	output isbs_pkg::entry_t head
);
	import isbs_pkg::*;

	entry_t ents [RING_DEPTH];

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % RING_DEPTH;
		isbs_cell u_cell (
			.clk(clk),
			.shift(ctl.shift),
			.wr_all(ctl.wr_all && (ctl.widx == IDX_W'(i))),
			.wr_ang(ctl.wr_ang && (ctl.widx == IDX_W'(i))),
			.wdata(wdata),
			.nbr(ents[NXT]),
			.ent(ents[i])
		);
	end

	assign head = ents[0];
endmodule

/* test/imu_timestamp_sync_buffer_top_tb.sv */
// Testbench of the orientation sample buffer: directed table, then random sequences of adds,
// queries and clears, all checked against a behavioral copy of the ring. Depends on isbs_pkg.
`timescale 1ns / 1ps
module imu_timestamp_sync_buffer_top_tb;
	import isbs_pkg::*;

	localparam int DIRECTED_N = 20;
	localparam int RANDOM_N = 850;
	localparam longint CYCLE_LIMIT = 600000;
	localparam int EXP_DEPTH = 256;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_t in_data;
	out_t out_data;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	imu_timestamp_sync_buffer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: a plain copy of the ring.
	entry_t ring [RING_DEPTH];
	int unsigned head, held;
	logic [31:0] retention, qlimit, ematch;
	// Expected results in order of acceptance; written at exp_wr, read at exp_rd.
	out_t exp_fifo [EXP_DEPTH];
	int exp_wr, exp_rd;
	int errors, results_seen;
	longint cycles;

	typedef struct {
		in_t item;
		logic checked;
		out_t result;
	} row_t;
	row_t rows [DIRECTED_N];

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("imu_timestamp_sync_buffer_top_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic int unsigned slot(int unsigned i);
		return (head + i) % RING_DEPTH;
	endfunction

	function automatic logic [31:0] distance(logic [31:0] a, logic [31:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic void push_entry(entry_t e);
		if (held >= RING_DEPTH) begin
			head = slot(1);
			held = RING_DEPTH - 1;
		end
		ring[slot(held)] = e;
		held++;
	endfunction

	function automatic void drop_old();
		longint cutoff;
		if (held == 0) return;
		cutoff = longint'(ring[slot(held - 1)].stamp) - longint'(retention);
		while (held > 0 && longint'(ring[head].stamp) < cutoff) begin
			head = slot(1);
			held--;
		end
	endfunction

	function automatic out_t predict_sample(in_t it);
		out_t r;
		entry_t e;
		int unsigned best, pick;
		logic [31:0] bestd, d;
		r = '0;
		e = '0;
		case (it.opcode)
			OP_ADD_QUAT: begin
				e.stamp = it.sample_time;
				e.qw = it.quat_w; e.qx = it.quat_x; e.qy = it.quat_y; e.qz = it.quat_z;
				push_entry(e);
				drop_old();
			end
			OP_ADD_EULER: begin
				if (held == 0) begin
					e.stamp = it.sample_time;
					e.qw = QUAT_ONE;
					e.roll = it.roll_in; e.pitch = it.pitch_in; e.yaw = it.yaw_in;
					e.euler = 1'b1;
					push_entry(e);
				end else begin
					for (int k = held; k > 0; k--) begin
						if (distance(ring[slot(k - 1)].stamp, it.sample_time) < ematch) begin
							ring[slot(k - 1)].roll = it.roll_in;
							ring[slot(k - 1)].pitch = it.pitch_in;
							ring[slot(k - 1)].yaw = it.yaw_in;
							ring[slot(k - 1)].euler = 1'b1;
							break;
						end
					end
				end
				drop_old();
			end
			OP_QUERY: begin
				if (held > 0) begin
					best = slot(0);
					bestd = distance(ring[best].stamp, it.sample_time);
					for (int k = 1; k < held; k++) begin
						d = distance(ring[slot(k)].stamp, it.sample_time);
						if (d < bestd) begin
							bestd = d;
							best = slot(k);
						end
					end
					pick = (bestd < qlimit) ? best : slot(held - 1);
					e = ring[pick];
					r.found = 1'b1;
					r.out_time = e.stamp;
					r.out_quat_w = e.qw; r.out_quat_x = e.qx;
					r.out_quat_y = e.qy; r.out_quat_z = e.qz;
					r.out_roll = e.roll; r.out_pitch = e.pitch; r.out_yaw = e.yaw;
					r.out_has_euler = e.euler;
				end
			end
			default: begin
				held = 0;
				head = 0;
			end
		endcase
		r.occupancy = held[5:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic compare_result(string tag, out_t got, out_t want);
		if (got.found !== want.found)
			report_mismatch({tag, " found"}, 64'(got.found), 64'(want.found));
		if (got.out_time !== want.out_time)
			report_mismatch({tag, " out_time"}, 64'(got.out_time), 64'(want.out_time));
		if (got.out_quat_w !== want.out_quat_w)
			report_mismatch({tag, " out_quat_w"}, 64'(got.out_quat_w), 64'(want.out_quat_w));
		if (got.out_quat_x !== want.out_quat_x)
			report_mismatch({tag, " out_quat_x"}, 64'(got.out_quat_x), 64'(want.out_quat_x));
		if (got.out_quat_y !== want.out_quat_y)
			report_mismatch({tag, " out_quat_y"}, 64'(got.out_quat_y), 64'(want.out_quat_y));
		if (got.out_quat_z !== want.out_quat_z)
			report_mismatch({tag, " out_quat_z"}, 64'(got.out_quat_z), 64'(want.out_quat_z));
		if (got.out_roll !== want.out_roll)
			report_mismatch({tag, " out_roll"}, 64'(got.out_roll), 64'(want.out_roll));
		if (got.out_pitch !== want.out_pitch)
			report_mismatch({tag, " out_pitch"}, 64'(got.out_pitch), 64'(want.out_pitch));
		if (got.out_yaw !== want.out_yaw)
			report_mismatch({tag, " out_yaw"}, 64'(got.out_yaw), 64'(want.out_yaw));
		if (got.out_has_euler !== want.out_has_euler)
			report_mismatch({tag, " out_has_euler"}, 64'(got.out_has_euler),
				64'(want.out_has_euler));
		if (got.occupancy !== want.occupancy)
			report_mismatch({tag, " occupancy"}, 64'(got.occupancy), 64'(want.occupancy));
	endtask

	// Result side: random stalls on a pattern, compare at the rising edge.
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				out_t w;
				results_seen++;
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected result", 64'(out_data.out_time), 64'd0);
				end else begin
					w = exp_fifo[exp_rd % EXP_DEPTH];
					exp_rd++;
					compare_result("result", out_data, w);
				end
			end
			@(negedge clk);
			// Long stretches of always-ready alternate with stall-heavy stretches.
			if ((cycles / 500) % 3 == 0) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic write_reg(logic [1:0] index, logic [31:0] value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * index); pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (index)
			REG_RETENTION: retention = value;
			REG_QUERY_LIMIT: qlimit = value;
			default: ematch = value;
		endcase
	endtask

	// Hands one item over; valid stays high until the transfer.
	task automatic send_sample(in_t it, logic typed, out_t typed_result);
		out_t p;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = predict_sample(it);
		if (typed) compare_result("directed table row", p, typed_result);
		exp_fifo[exp_wr % EXP_DEPTH] = p;
		exp_wr++;
	endtask

	task automatic idle_gap();
		@(negedge clk);
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic in_t make_item(logic [1:0] op, logic [31:0] t);
		in_t it;
		it = '0;
		it.opcode = op;
		it.sample_time = t;
		it.quat_w = 16'($urandom); it.quat_x = 16'($urandom);
		it.quat_y = 16'($urandom); it.quat_z = 16'($urandom);
		it.roll_in = 16'($urandom); it.pitch_in = 16'($urandom); it.yaw_in = 16'($urandom);
		return it;
	endfunction

	function automatic out_t occ_only(int n);
		out_t r;
		r = '0;
		r.occupancy = n[5:0];
		return r;
	endfunction

	initial begin
		in_t it;
		out_t r;
		logic [31:0] now;
		int burst, op_pick, mode;
		errors = 0; results_seen = 0;
		exp_wr = 0; exp_rd = 0;
		in_valid = 0; in_data = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		head = 0; held = 0;
		retention = RETENTION_RESET; qlimit = QUERY_LIMIT_RESET; ematch = EULER_MATCH_RESET;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed table: empty-ring cases, identity quaternion, extremes, clear.
		r = '0;
		rows[0] = '{make_item(OP_QUERY, 32'd0), 1, occ_only(0)};
		rows[1] = '{make_item(OP_ADD_EULER, 32'd500), 0, r};
		rows[2] = '{make_item(OP_QUERY, 32'd500), 0, r};
		rows[3] = '{make_item(OP_ADD_QUAT, 32'd1000), 1, occ_only(2)};
		rows[4] = '{make_item(OP_ADD_EULER, 32'd1200), 0, r};
		rows[5] = '{make_item(OP_ADD_EULER, 32'd900000), 0, r};
		rows[6] = '{make_item(OP_QUERY, 32'd1100), 0, r};
		rows[7] = '{make_item(OP_QUERY, 32'd50000), 0, r};
		rows[8] = '{make_item(OP_CLEAR, 32'hFFFF_FFFF), 1, occ_only(0)};
		rows[9] = '{make_item(OP_ADD_QUAT, 32'd0), 0, r};
		rows[10] = '{make_item(OP_ADD_QUAT, 32'hFFFF_FFFF), 1, occ_only(1)};
		rows[11] = '{make_item(OP_QUERY, 32'hFFFF_FFFF), 0, r};
		rows[12] = '{make_item(OP_ADD_QUAT, 32'd200), 0, r};
		rows[13] = '{make_item(OP_ADD_QUAT, 32'd20), 0, r};
		rows[14] = '{make_item(OP_QUERY, 32'd110), 0, r};
		rows[15] = '{make_item(OP_CLEAR, 32'd0), 1, occ_only(0)};
		for (int i = 0; i < 4; i++) begin
			rows[16 + i] = '{make_item(OP_ADD_QUAT, 32'd100 * i), 0, r};
			rows[16 + i].item.quat_w = (i % 2) ? 16'sh7FFF : 16'sh8000;
			rows[16 + i].item.roll_in = (i % 2) ? 16'sh8000 : 16'sh7FFF;
		end
		for (int i = 0; i < DIRECTED_N; i++)
			send_sample(rows[i].item, rows[i].checked, rows[i].result);
		drain();

		// Random phases, each under its own register setting; extremes included.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_RETENTION, 32'd1);
					write_reg(REG_QUERY_LIMIT, 32'd1); write_reg(REG_EULER_MATCH, 32'd1); end
				1: begin write_reg(REG_RETENTION, 32'hFFFF_FFFF);
					write_reg(REG_QUERY_LIMIT, 32'hFFFF_FFFF);
					write_reg(REG_EULER_MATCH, 32'hFFFF_FFFF); end
				default: begin write_reg(REG_RETENTION, $urandom_range(50, 4000));
					write_reg(REG_QUERY_LIMIT, $urandom_range(1, 300));
					write_reg(REG_EULER_MATCH, $urandom_range(1, 300)); end
			endcase
			now = (phase == 3) ? 32'hFFFF_F000 : $urandom;
			mode = 0;
			while (mode < RANDOM_N / 6) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && mode < RANDOM_N / 6; b++, mode++) begin
					op_pick = $urandom_range(0, 99);
					// Mostly rising timestamps, with a few steps back and wild values.
					if ($urandom_range(0, 19) == 0) now = $urandom;
					else if ($urandom_range(0, 9) == 0) now = now - $urandom_range(0, 200);
					else now = now + $urandom_range(0, 120);
					if (op_pick < 45) it = make_item(OP_ADD_QUAT, now);
					else if (op_pick < 70)
						it = make_item(OP_ADD_EULER, now - $urandom_range(0, 300));
					else if (op_pick < 97)
						it = make_item(OP_QUERY, now - $urandom_range(0, 600));
					else it = make_item(OP_CLEAR, $urandom);
					send_sample(it, 0, r);
				end
				if ($urandom_range(0, 3) != 0) idle_gap();
			end
			drain();
		end

		$display("run covered %0d results over directed rows and six register settings",
			results_seen);
		$display("mismatches: %0d", errors);
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("imu_timestamp_sync_buffer_top_tb: PASS");
		end else begin
			$display("imu_timestamp_sync_buffer_top_tb: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/isbs_pkg.sv
rtl/isbs_cell.sv
rtl/isbs_chain.sv
rtl/imu_timestamp_sync_buffer_top.sv
test/imu_timestamp_sync_buffer_top_tb.sv
